FILE: hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fgpr_pkg.sv
package fgpr_pkg;

	localparam int ADDR_W  = 17;
	localparam int COLOR_W = 16;
	localparam int COORD_W = 12;
	localparam int POS_W   = 14;
	localparam int EDGE_W  = 10;
	localparam int ALPHA_W = 8;
	localparam int SCALE_W = 3;

	localparam logic [2:0] FONT_W = 3'd5;
	localparam logic [2:0] FONT_H = 3'd7;

	localparam logic [ALPHA_W-1:0] ALPHA_MAX  = 8'd255;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd250;

	localparam logic [2:0] REG_TEXT_COLOR  = 3'd0;
	localparam logic [2:0] REG_FADE_COLOR  = 3'd1;
	localparam logic [2:0] REG_CLIP_LEFT   = 3'd2;
	localparam logic [2:0] REG_CLIP_RIGHT  = 3'd3;
	localparam logic [2:0] REG_FADE_WIDTH  = 3'd4;
	localparam logic [2:0] REG_GLYPH_SCALE = 3'd5;

	localparam logic [COLOR_W-1:0] TEXT_COLOR_RST  = 16'hFFFF;
	localparam logic [COLOR_W-1:0] FADE_COLOR_RST  = 16'h0000;
	localparam logic [COORD_W-1:0] CLIP_LEFT_RST   = 12'd0;
	localparam logic [COORD_W-1:0] CLIP_RIGHT_RST  = 12'd640;
	localparam logic [EDGE_W-1:0]  FADE_WIDTH_RST  = 10'd0;
	localparam logic [SCALE_W-1:0] GLYPH_SCALE_RST = 3'd2;

	typedef struct packed {
		logic [COLOR_W-1:0] text_color;
		logic [COLOR_W-1:0] fade_color;
		logic [COORD_W-1:0] clip_left;
		logic [COORD_W-1:0] clip_right;
		logic [EDGE_W-1:0]  fade_width;
		logic [SCALE_W-1:0] glyph_scale;
	} cfg_t;

	typedef struct packed {
		logic              wr;
		logic              fade;
		logic [ADDR_W-1:0] addr;
	} side_t;

	// font rows top to bottom, bit 4 is the leftmost column
	function automatic logic [34:0] glyph_bits(input logic [7:0] code);
		logic [7:0]  c;
		logic [34:0] g;
		begin
			c = code;
			if (code >= 8'h61 && code <= 8'h7A) begin
				c = code - 8'h20;
			end
			case (c)
				8'h21: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
				8'h22: g = {5'h0A, 5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00};
				8'h23: g = {5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
				8'h25: g = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
				8'h26: g = {5'h0C, 5'h12, 5'h14, 5'h08, 5'h15, 5'h12, 5'h0D};
				8'h27: g = {5'h04, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00};
				8'h28: g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
				8'h29: g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
				8'h2A: g = {5'h00, 5'h15, 5'h0E, 5'h1F, 5'h0E, 5'h15, 5'h00};
				8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
				8'h2C: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h04, 5'h08};
				8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
				8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
				8'h2F: g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
				8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
				8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
				8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
				8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
				8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
				8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
				8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
				8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
				8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
				8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
				8'h3A: g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
				8'h3B: g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h06, 5'h04, 5'h08};
				8'h3E: g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
				8'h3F: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
				8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
				8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
				8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
				8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
				8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
				8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
				8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
				8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
				8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
				8'h4A: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
				8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
				8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
				8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
				8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
				8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
				8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
				8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
				8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
				8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
				8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
				8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
				8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
				8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
				8'h58: g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11};
				8'h59: g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
				8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
				8'h5F: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
				default: g = '0;
			endcase
			return g;
		end
	endfunction

	function automatic logic [4:0] font_row(input logic [7:0] code, input logic [2:0] row);
		logic [34:0] g;
		logic [4:0]  r;
		begin
			g = glyph_bits(code);
			case (row)
				3'd0: r = g[34:30];
				3'd1: r = g[29:25];
				3'd2: r = g[24:20];
				3'd3: r = g[19:15];
				3'd4: r = g[14:10];
				3'd5: r = g[9:5];
				3'd6: r = g[4:0];
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: hdl/fgpr_front.sv
module fgpr_front import fgpr_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 172
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          char_code,
	input  logic [COORD_W-1:0]  origin_x,
	input  logic [COORD_W-1:0]  origin_y,
	input  logic [4:0]          cell_col,
	input  logic [4:0]          cell_row,
	input  cfg_t                cfg,
	output logic                out_valid,
	output side_t               out_side,
	output logic [EDGE_W-1:0]   out_edge,
	output logic [EDGE_W-1:0]   out_fw
);

	localparam logic signed [POS_W-1:0] FW_S  = POS_W'(FRAME_WIDTH);
	localparam logic signed [POS_W-1:0] FH_S  = POS_W'(FRAME_HEIGHT);
	localparam logic [ADDR_W-1:0]       FW_A  = ADDR_W'(FRAME_WIDTH);

	// quotient of a cell position by the scale, saturating at seven
	function automatic logic [2:0] small_div(input logic [4:0] n, input logic [2:0] d);
		logic [2:0] q;
		logic [5:0] lim;
		begin
			q = '0;
			for (int k = 1; k < 8; k++) begin
				lim = 6'(k) * {3'b000, d};
				if ({1'b0, n} >= lim) begin
					q = q + 3'd1;
				end
			end
			return q;
		end
	endfunction

	logic                    v_s1;
	logic [7:0]              code_s1;
	logic [2:0]              fcol_s1;
	logic [2:0]              frow_s1;
	logic                    box_s1;
	logic signed [POS_W-1:0] x_s1;
	logic signed [POS_W-1:0] y_s1;

	logic [2:0]              fcol_d;
	logic [2:0]              frow_d;

	assign fcol_d = small_div(cell_col, cfg.glyph_scale);
	assign frow_d = small_div(cell_row, cfg.glyph_scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		code_s1 <= char_code;
		fcol_s1 <= fcol_d;
		frow_s1 <= frow_d;
		box_s1  <= (fcol_d < FONT_W) && (frow_d < FONT_H);
		x_s1    <= $signed({{2{origin_x[COORD_W-1]}}, origin_x}) + $signed({9'b0, cell_col});
		y_s1    <= $signed({{2{origin_y[COORD_W-1]}}, origin_y}) + $signed({9'b0, cell_row});
	end

	// second stage: font bit, frame and clip tests, edge distance, address
	logic [4:0]              row_bits;
	logic [4:0]              row_shift;
	logic                    font_hit;
	logic signed [POS_W-1:0] cl;
	logic signed [POS_W-1:0] cr;
	logic signed [POS_W-1:0] dl;
	logic signed [POS_W-1:0] dr;
	logic signed [POS_W-1:0] edge_min;
	logic                    on_frame;
	logic                    in_clip;
	logic                    wr_d;
	logic                    fade_d;
	logic [ADDR_W-1:0]       addr_d;

	always_comb begin
		row_bits  = font_row(code_s1, frow_s1);
		row_shift = 5'(row_bits << fcol_s1);
		font_hit  = box_s1 && row_shift[4];
		cl        = $signed({{2{cfg.clip_left[COORD_W-1]}}, cfg.clip_left});
		cr        = $signed({{2{cfg.clip_right[COORD_W-1]}}, cfg.clip_right});
		on_frame  = (y_s1 >= 0) && (y_s1 < FH_S) && (x_s1 >= 0) && (x_s1 < FW_S);
		in_clip   = (x_s1 >= cl) && (x_s1 < cr);
		wr_d      = font_hit && on_frame && in_clip;
		dl        = x_s1 - cl;
		dr        = cr - POS_W'(1) - x_s1;
		edge_min  = (dl < dr) ? dl : dr;
		fade_d    = wr_d && (cfg.fade_width != '0)
			&& (edge_min < $signed({4'b0000, cfg.fade_width}));
		addr_d    = ADDR_W'(ADDR_W'(y_s1[12:0]) * FW_A) + ADDR_W'(x_s1[12:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_side.wr   <= wr_d;
		out_side.fade <= fade_d;
		out_side.addr <= addr_d;
		out_edge      <= edge_min[EDGE_W-1:0];
		out_fw        <= cfg.fade_width;
	end

endmodule

FILE: hdl/fgpr_alpha_div.sv
module fgpr_alpha_div import fgpr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_in,
	input  side_t               side_in,
	input  logic [EDGE_W-1:0]   edge_in,
	input  logic [EDGE_W-1:0]   fw_in,
	output logic                v_out,
	output side_t               side_out,
	output logic [ALPHA_W-1:0]  alpha_out
);

	`include "assert_macros.svh"

	// two restoring steps; remainder stays below the divisor
	function automatic logic [EDGE_W+1:0] div_step(
		input logic [EDGE_W-1:0] rem,
		input logic [1:0]        nb,
		input logic [EDGE_W-1:0] d
	);
		logic [EDGE_W:0]   t;
		logic [EDGE_W-1:0] r;
		logic [1:0]        q;
		begin
			r = rem;
			q = '0;
			for (int i = 1; i >= 0; i--) begin
				t = {r, nb[i]};
				if (t >= {1'b0, d}) begin
					t    = t - {1'b0, d};
					q[i] = 1'b1;
				end
				r = t[EDGE_W-1:0];
			end
			return {r, q};
		end
	endfunction

	logic [17:0]        num;
	logic [EDGE_W+1:0]  st3;
	logic [EDGE_W+1:0]  st4;
	logic [EDGE_W+1:0]  st5;
	logic [EDGE_W+1:0]  st6;

	logic               v_s3, v_s4, v_s5, v_s6;
	side_t              side_s3, side_s4, side_s5, side_s6;
	logic [EDGE_W-1:0]  d_s3, d_s4, d_s5;
	logic [EDGE_W-1:0]  rem_s3, rem_s4, rem_s5;
	logic [5:0]         low_s3;
	logic [3:0]         low_s4;
	logic [1:0]         low_s5;
	logic [1:0]         q_s3;
	logic [3:0]         q_s4;
	logic [5:0]         q_s5;
	logic [7:0]         q_s6;

	// edge * 255, high bits seed the remainder
	assign num = {edge_in, 8'b0} - {8'b0, edge_in};
	assign st3 = div_step(num[17:8], num[7:6], fw_in);
	assign st4 = div_step(rem_s3, low_s3[5:4], d_s3);
	assign st5 = div_step(rem_s4, low_s4[3:2], d_s4);
	assign st6 = div_step(rem_s5, low_s5, d_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s3 <= v_in;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_in;
		d_s3    <= fw_in;
		rem_s3  <= st3[EDGE_W+1:2];
		q_s3    <= st3[1:0];
		low_s3  <= num[5:0];

		side_s4 <= side_s3;
		d_s4    <= d_s3;
		rem_s4  <= st4[EDGE_W+1:2];
		q_s4    <= {q_s3, st4[1:0]};
		low_s4  <= low_s3[3:0];

		side_s5 <= side_s4;
		d_s5    <= d_s4;
		rem_s5  <= st5[EDGE_W+1:2];
		q_s5    <= {q_s4, st5[1:0]};
		low_s5  <= low_s4[1:0];

		side_s6 <= side_s5;
		q_s6    <= {q_s5, st6[1:0]};
	end

	assign v_out     = v_s6;
	assign side_out  = side_s6;
	assign alpha_out = q_s6;

	`ASSERT_IMPLIES(a_fade_alpha_below_max, v_s6 && side_s6.fade, q_s6 != ALPHA_MAX, "fade alpha reached full scale")
	`ASSERT_ALWAYS(a_div_latency, v_s6 == $past(v_in, 4), "divider valid lost or invented")

endmodule

FILE: hdl/fgpr_blend.sv
module fgpr_blend import fgpr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_in,
	input  side_t               side_in,
	input  logic [ALPHA_W-1:0]  alpha_in,
	input  cfg_t                cfg,
	output logic                result_valid,
	output logic                write_enable,
	output logic [ADDR_W-1:0]   pixel_address,
	output logic [COLOR_W-1:0]  pixel_value
);

	// exact x / 255 for every 14-bit x
	function automatic logic [7:0] div255(input logic [13:0] x);
		logic [15:0] t;
		begin
			t = {2'b00, x} + 16'(x >> 8) + 16'd1;
			return t[15:8];
		end
	endfunction

	logic [ALPHA_W-1:0] a;
	logic [ALPHA_W-1:0] inv;

	logic               v_s7;
	side_t              side_s7;
	logic               full_s7;
	logic               zero_s7;
	logic [13:0]        sr_s7, sg_s7, sb_s7;

	assign a   = side_in.fade ? alpha_in : ALPHA_MAX;
	assign inv = ALPHA_MAX - a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_in;
		full_s7 <= a >= ALPHA_FULL;
		zero_s7 <= a == '0;
		sr_s7   <= 14'(cfg.text_color[15:11]) * 14'(a) + 14'(cfg.fade_color[15:11]) * 14'(inv);
		sg_s7   <= 14'(cfg.text_color[10:5]) * 14'(a) + 14'(cfg.fade_color[10:5]) * 14'(inv);
		sb_s7   <= 14'(cfg.text_color[4:0]) * 14'(a) + 14'(cfg.fade_color[4:0]) * 14'(inv);
	end

	logic [7:0]         qr, qg, qb;
	logic [COLOR_W-1:0] color;

	always_comb begin
		qr = div255(sr_s7);
		qg = div255(sg_s7);
		qb = div255(sb_s7);
		if (full_s7) begin
			color = cfg.text_color;
		end else if (zero_s7) begin
			color = cfg.fade_color;
		end else begin
			color = {qr[4:0], qg[5:0], qb[4:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			write_enable <= 1'b0;
		end else begin
			result_valid <= v_s7;
			write_enable <= v_s7 && side_s7.wr;
		end
	end

	always_ff @(posedge clk) begin
		pixel_address <= (v_s7 && side_s7.wr) ? side_s7.addr : '0;
		pixel_value   <= (v_s7 && side_s7.wr) ? {color[7:0], color[15:8]} : '0;
	end

endmodule

FILE: hdl/faded_glyph_pixel_rasterizer.sv
// scaled 5x7 glyph pixel rasterizer with clip window and edge fade
//
// pixel channel: pulse start with char_code, origin_x, origin_y, cell_col and
// cell_row; busy is always low, so a new pixel beat is taken every cycle.
// result channel: result_valid is high for one cycle with write_enable,
// pixel_address and pixel_value (byte-swapped rgb565); address and value read
// zero when write_enable is low. every pixel beat gives exactly one result.
// throughput one pixel per cycle; the 8 stages are two for font lookup and
// clip tests, four for the 2-bit-per-stage alpha divider and two for the
// per-channel blend.
// config: apb registers at 4*i (text_color, fade_color, clip_left, clip_right,
// fade_width, glyph_scale), pready always high; write only while idle.
// reset clears the pipeline valids and loads the register defaults.
// the receiver cannot stall: results are presented once and never held.
module faded_glyph_pixel_rasterizer import fgpr_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 172
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [7:0]          char_code,
	input  logic [COORD_W-1:0]  origin_x,
	input  logic [COORD_W-1:0]  origin_y,
	input  logic [4:0]          cell_col,
	input  logic [4:0]          cell_row,
	output logic                result_valid,
	output logic                write_enable,
	output logic [ADDR_W-1:0]   pixel_address,
	output logic [COLOR_W-1:0]  pixel_value,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	`include "assert_macros.svh"

	cfg_t       cfg_q;
	logic [2:0] reg_sel;
	logic       cfg_wr;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color  <= TEXT_COLOR_RST;
			cfg_q.fade_color  <= FADE_COLOR_RST;
			cfg_q.clip_left   <= CLIP_LEFT_RST;
			cfg_q.clip_right  <= CLIP_RIGHT_RST;
			cfg_q.fade_width  <= FADE_WIDTH_RST;
			cfg_q.glyph_scale <= GLYPH_SCALE_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_TEXT_COLOR:  cfg_q.text_color  <= pwdata[COLOR_W-1:0];
				REG_FADE_COLOR:  cfg_q.fade_color  <= pwdata[COLOR_W-1:0];
				REG_CLIP_LEFT:   cfg_q.clip_left   <= pwdata[COORD_W-1:0];
				REG_CLIP_RIGHT:  cfg_q.clip_right  <= pwdata[COORD_W-1:0];
				REG_FADE_WIDTH:  cfg_q.fade_width  <= pwdata[EDGE_W-1:0];
				REG_GLYPH_SCALE: cfg_q.glyph_scale <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TEXT_COLOR:  prdata = 32'(cfg_q.text_color);
			REG_FADE_COLOR:  prdata = 32'(cfg_q.fade_color);
			REG_CLIP_LEFT:   prdata = 32'(cfg_q.clip_left);
			REG_CLIP_RIGHT:  prdata = 32'(cfg_q.clip_right);
			REG_FADE_WIDTH:  prdata = 32'(cfg_q.fade_width);
			REG_GLYPH_SCALE: prdata = 32'(cfg_q.glyph_scale);
			default:         prdata = '0;
		endcase
	end

	logic               front_v;
	side_t              front_side;
	logic [EDGE_W-1:0]  front_edge;
	logic [EDGE_W-1:0]  front_fw;
	logic               div_v;
	side_t              div_side;
	logic [ALPHA_W-1:0] div_alpha;

	fgpr_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.char_code (char_code),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.cell_col  (cell_col),
		.cell_row  (cell_row),
		.cfg       (cfg_q),
		.out_valid (front_v),
		.out_side  (front_side),
		.out_edge  (front_edge),
		.out_fw    (front_fw)
	);

	fgpr_alpha_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (front_v),
		.side_in   (front_side),
		.edge_in   (front_edge),
		.fw_in     (front_fw),
		.v_out     (div_v),
		.side_out  (div_side),
		.alpha_out (div_alpha)
	);

	fgpr_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.v_in          (div_v),
		.side_in       (div_side),
		.alpha_in      (div_alpha),
		.cfg           (cfg_q),
		.result_valid  (result_valid),
		.write_enable  (write_enable),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value)
	);

	`ASSERT_IMPLIES(a_write_has_strobe, write_enable, result_valid, "write without result strobe")
	`ASSERT_IMPLIES(a_nowrite_zero, !write_enable, pixel_address == '0 && pixel_value == '0, "fields not zero without write")

endmodule
